### sv/frustum_cull_test_assert.svh
// assertion macros for the frustum cull test block
`ifndef FRUSTUM_CULL_TEST_ASSERT_SVH
`define FRUSTUM_CULL_TEST_ASSERT_SVH

// condition implies consequence in the same cycle
`define FCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fct_pkg.sv
// shared constants and types for the frustum cull test block
`default_nettype none

package fct_pkg;

    localparam int PLANE_COUNT    = 6;
    localparam int NUM_PLANE_REGS = 6;
    localparam int TEST_PLANES    = (PLANE_COUNT < NUM_PLANE_REGS) ? PLANE_COUNT
                                                                   : NUM_PLANE_REGS;
    localparam int CFG_IDX_W      = $clog2(NUM_PLANE_REGS);
    localparam int NORMAL_SHIFT   = 14;
    localparam int COORD_W        = 16;
    localparam int RADIUS_W       = 15;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int TERM_W         = COORD_W + 1 + NORMAL_SHIFT;
    localparam int SUM_W          = PROD_W + 2;

    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic                op;
        coord_t [2:0]        first_c;
        coord_t [2:0]        second_c;
        logic [RADIUS_W-1:0] radius;
    } item_t;

    typedef struct packed {
        logic en2;
        logic en3;
    } pipe_en_t;

endpackage

`default_nettype wire

### sv/frustum_cull_test.sv
// frustum cull test: each input transfer yields one result transfer
// throughput one item per cycle; stages: input reg, products, distance compare, output
// the pipeline stalls only when the result side holds m_tready low; bubbles are filled
// synchronous active-low reset clears the valid bits and all plane registers to zero
// plane registers are read live, so the user must change them only while no item is in flight; not enforced here
`default_nettype none

`include "frustum_cull_test_assert.svh"

module frustum_cull_test
    import fct_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, radius, zero pad
    input  wire logic [111:0]         s_tdata,
    // operation
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // visible, zero pad
    output logic [7:0]                m_tdata
);

    logic [63:0]            plane_reg [NUM_PLANE_REGS];
    item_t                  item_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   out_valid_reg;
    logic                   visible_reg;
    logic                   en1;
    logic                   en4;
    pipe_en_t               pipe_en;
    logic [TEST_PLANES-1:0] reject;
    item_t                  item_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANE_REGS; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < NUM_PLANE_REGS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    // stage enables: a stage moves when empty or when the one after moves
    assign en4         = !out_valid_reg || m_tready;
    assign pipe_en.en3 = !v3_reg || en4;
    assign pipe_en.en2 = !v2_reg || pipe_en.en3;
    assign en1         = !v1_reg || pipe_en.en2;
    assign s_tready    = en1;

    always_comb begin
        item_next.op          = s_tuser;
        item_next.first_c[0]  = coord_t'(s_tdata[15:0]);
        item_next.first_c[1]  = coord_t'(s_tdata[31:16]);
        item_next.first_c[2]  = coord_t'(s_tdata[47:32]);
        item_next.second_c[0] = coord_t'(s_tdata[63:48]);
        item_next.second_c[1] = coord_t'(s_tdata[79:64]);
        item_next.second_c[2] = coord_t'(s_tdata[95:80]);
        item_next.radius      = s_tdata[110:96];
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (pipe_en.en2) begin
                v2_reg <= v1_reg;
            end
            if (pipe_en.en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    for (genvar p = 0; p < TEST_PLANES; p++) begin : g_plane
        fct_plane u_plane (
            .aclk    (aclk),
            .plane   (plane_reg[p]),
            .item    (item_reg),
            .pipe_en (pipe_en),
            .reject  (reject[p])
        );
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            visible_reg <= ~|reject;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, visible_reg};

    `FCT_ASSERT_NEXT(a_stage3_reaches_out, (v3_reg && en4), m_tvalid,
        "compare stage item did not reach the output register")
    `FCT_ASSERT_SAME(a_stall_only_when_full, !s_tready,
        (v1_reg && v2_reg && v3_reg && out_valid_reg),
        "input stalled while a pipeline stage was empty")
    `FCT_ASSERT_NEXT(a_out_held_on_stall, (m_tvalid && !m_tready),
        (m_tvalid && $stable(visible_reg)),
        "stalled result changed or vanished")

endmodule

`default_nettype wire

### sv/fct_plane.sv
// one plane of the cull test: corner select, products, distance compare
`default_nettype none

module fct_plane
    import fct_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [63:0] plane,
    input  wire item_t       item,
    input  wire pipe_en_t    pipe_en,
    output logic             reject
);

    coord_t                      normal [3];
    coord_t                      w_off;
    coord_t                      corner [3];
    logic signed [PROD_W-1:0]    prod_next [3];
    logic signed [PROD_W-1:0]    prod_reg [3];
    logic signed [COORD_W:0]     wr_sum;
    logic signed [TERM_W-1:0]    term_next;
    logic signed [TERM_W-1:0]    term_reg;
    logic                        op_reg;
    logic signed [SUM_W-1:0]     dist_sum;
    logic                        reject_next;
    logic                        reject_reg;

    always_comb begin
        normal[0] = coord_t'(plane[15:0]);
        normal[1] = coord_t'(plane[31:16]);
        normal[2] = coord_t'(plane[47:32]);
        w_off     = coord_t'(plane[63:48]);
        for (int i = 0; i < 3; i++) begin
            // box: furthest corner along the normal; sphere: the center
            if (item.op == OP_BOX && !normal[i][COORD_W-1]) begin
                corner[i] = item.second_c[i];
            end else begin
                corner[i] = item.first_c[i];
            end
            prod_next[i] = PROD_W'(normal[i]) * PROD_W'(corner[i]);
        end
        // sphere folds the radius into the offset so both tests compare with zero
        wr_sum = (COORD_W+1)'(w_off);
        if (item.op == OP_SPHERE) begin
            wr_sum = wr_sum + $signed({2'b00, item.radius});
        end
        term_next = {wr_sum, {NORMAL_SHIFT{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.en2) begin
            prod_reg <= prod_next;
            term_reg <= term_next;
            op_reg   <= item.op;
        end
    end

    always_comb begin
        dist_sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                 + SUM_W'(term_reg);
        if (op_reg == OP_BOX) begin
            reject_next = dist_sum[SUM_W-1];
        end else begin
            reject_next = dist_sum[SUM_W-1] || (dist_sum == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.en3) begin
            reject_reg <= reject_next;
        end
    end

    assign reject = reject_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for the frustum cull block: directed and random sphere/box items checked by a predictor
module tb_top;
    import fct_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int CHUNK_ITEMS = 130;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR    = 5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = {CFG_IDX_W{1'b1}};

    typedef enum int {PLANES_CUBE, PLANES_RANDOM, PLANES_EXTREME} plane_style_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // first_x, first_y, first_z, second_x, second_y, second_z, radius, zero pad
    logic [111:0]         s_tdata   = '0;
    // operation
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // visible, zero pad
    logic [7:0]           m_tdata;

    logic [63:0] plane_cfg [NUM_PLANE_REGS];
    item_t       pending_items [$];
    logic        expected_vis [$];
    item_t       cur_item;
    int          snd_idle_pct = 6;
    int          rcv_idle_pct = 47;
    int          n_accepted   = 0;
    int          n_cycles     = 0;
    int          n_err        = 0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;

    frustum_cull_test u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // visibility of one object against the configured planes
    function automatic logic cull_visible(item_t it);
        logic signed [15:0] nx, ny, nz, w;
        coord_t             px, py, pz;
        longint             dist_val;
        longint             rad;
        logic               vis;
        vis = 1'b1;
        rad = longint'(it.radius) * (longint'(1) << NORMAL_SHIFT);
        for (int i = 0; i < TEST_PLANES; i++) begin
            nx = plane_cfg[i][15:0];
            ny = plane_cfg[i][31:16];
            nz = plane_cfg[i][47:32];
            w  = plane_cfg[i][63:48];
            if (it.op == OP_SPHERE) begin
                px = it.first_c[0];
                py = it.first_c[1];
                pz = it.first_c[2];
            end else begin
                px = (nx >= 0) ? it.second_c[0] : it.first_c[0];
                py = (ny >= 0) ? it.second_c[1] : it.first_c[1];
                pz = (nz >= 0) ? it.second_c[2] : it.first_c[2];
            end
            dist_val = longint'(nx) * longint'(px) + longint'(ny) * longint'(py)
                     + longint'(nz) * longint'(pz)
                     + longint'(w) * (longint'(1) << NORMAL_SHIFT);
            if (it.op == OP_SPHERE) begin
                if (dist_val <= -rad) vis = 1'b0;
            end else begin
                if (dist_val < 0) vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic item_t make_item(logic op, int fx, int fy, int fz,
                                        int sx, int sy, int sz, int r);
        item_t it;
        it.op          = op;
        it.first_c[0]  = coord_t'(fx);
        it.first_c[1]  = coord_t'(fy);
        it.first_c[2]  = coord_t'(fz);
        it.second_c[0] = coord_t'(sx);
        it.second_c[1] = coord_t'(sy);
        it.second_c[2] = coord_t'(sz);
        it.radius      = RADIUS_W'(r);
        return it;
    endfunction

    function automatic coord_t rand_coord();
        if ($urandom_range(0, 1) != 0) return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 24000)) - 12000);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    v;
        it.op = ($urandom_range(0, 1) != 0) ? OP_BOX : OP_SPHERE;
        for (int k = 0; k < 3; k++) begin
            it.first_c[k] = rand_coord();
            if ($urandom_range(0, 4) != 0) begin
                v = int'(it.first_c[k]) + int'($urandom_range(0, 8000));
                it.second_c[k] = coord_t'((v > 32767) ? 32767 : v);
            end else begin
                it.second_c[k] = rand_coord();
            end
        end
        if ($urandom_range(0, 3) == 0) it.radius = RADIUS_W'($urandom_range(0, 32767));
        else it.radius = RADIUS_W'($urandom_range(0, 4000));
        return it;
    endfunction

    function automatic logic [15:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic exp_v, logic got_v);
        $display("ERROR %s: expected %0b got %0b at cycle %0d", what, exp_v, got_v, n_cycles);
        n_err++;
    endtask

    task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_PLANE_REGS) plane_cfg[idx] = data;
    endtask

    task automatic set_planes(plane_style_t style);
        logic [15:0] n [3];
        logic [15:0] w;
        for (int i = 0; i < NUM_PLANE_REGS; i++) begin
            case (style)
                PLANES_CUBE: begin
                    n = '{16'h0000, 16'h0000, 16'h0000};
                    n[i / 2] = (i % 2 == 0) ? 16'sd16384 : -16'sd16384;
                    w = 16'($urandom_range(2000, 20000));
                end
                PLANES_RANDOM: begin
                    n = '{16'($urandom), 16'($urandom), 16'($urandom)};
                    w = 16'($urandom);
                end
                default: begin
                    n = '{extreme_word(), extreme_word(), extreme_word()};
                    w = extreme_word();
                end
            endcase
            write_plane(CFG_IDX_W'(i), {w, n[2], n[1], n[0]});
        end
        // out-of-range index must leave the planes alone
        write_plane(($urandom_range(0, 1) != 0) ? REG_UNUSED : CFG_IDX_W'(NUM_PLANE_REGS),
                    {$urandom, $urandom});
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (!(pending_items.size() == 0 && !s_tvalid && expected_vis.size() == 0));
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_vis.push_back(cull_visible(cur_item));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tdata  <= {1'b0, cur_item.radius,
                                 cur_item.second_c[2], cur_item.second_c[1],
                                 cur_item.second_c[0], cur_item.first_c[2],
                                 cur_item.first_c[1], cur_item.first_c[0]};
                    s_tuser  <= cur_item.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline fills and backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && n_accepted == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_vis.size() == 0) begin
                    report_mismatch("unexpected result transfer", 1'b0, m_tdata[0]);
                end else if (expected_vis[0] !== m_tdata[0]) begin
                    report_mismatch("visible", expected_vis.pop_front(), m_tdata[0]);
                end else begin
                    void'(expected_vis.pop_front());
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("frustum_cull_test: mismatch");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_PLANE_REGS; i++) plane_cfg[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // planes still all zero after reset
        pending_items.push_back(make_item(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SPHERE, 0, 0, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(OP_SPHERE, -32768, 32767, -32768, 0, 0, 0, 32767));
        pending_items.push_back(make_item(OP_BOX, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_BOX, 32767, 32767, 32767,
                                          -32768, -32768, -32768, 0));
        pending_items.push_back(make_item(OP_BOX, -32768, -32768, -32768,
                                          32767, 32767, 32767, 32767));
        wait_drained();

        set_planes(PLANES_CUBE);
        pending_items.push_back(make_item(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SPHERE, 32767, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SPHERE, -32768, 0, 0, 0, 0, 0, 32767));
        pending_items.push_back(make_item(OP_SPHERE, 0, 0, 32767, 0, 0, 0, 32767));
        pending_items.push_back(make_item(OP_SPHERE, -32768, -32768, -32768,
                                          32767, 32767, 32767, 0));
        pending_items.push_back(make_item(OP_SPHERE, 32767, 32767, 32767,
                                          -32768, -32768, -32768, 32767));
        pending_items.push_back(make_item(OP_BOX, -100, -100, -100, 100, 100, 100, 0));
        pending_items.push_back(make_item(OP_BOX, 30000, 30000, 30000,
                                          32767, 32767, 32767, 0));
        pending_items.push_back(make_item(OP_BOX, -1000, -1000, -1000,
                                          30000, 100, 100, 32767));
        pending_items.push_back(make_item(OP_BOX, 100, 100, 100, -100, -100, -100, 0));
        pending_items.push_back(make_item(OP_BOX, 32767, 0, 0, -32768, 0, 0, 0));
        pending_items.push_back(make_item(OP_BOX, -32768, -32768, -32768,
                                          32767, 32767, 32767, 0));
        pending_items.push_back(make_item(OP_BOX, -32768, -32768, -32768,
                                          -32768, -32768, -32768, 32767));
        pending_items.push_back(make_item(OP_BOX, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767));
        wait_drained();

        // fixed plane order write, then random chunks
        write_plane(REG_LEFT,   {16'sd4000,  16'h0000,  16'h0000,  16'sd16384});
        write_plane(REG_RIGHT,  {16'sd4000,  16'h0000,  16'h0000, -16'sd16384});
        write_plane(REG_BOTTOM, {16'sd4000,  16'h0000,  16'sd16384, 16'h0000});
        write_plane(REG_TOP,    {16'sd4000,  16'h0000, -16'sd16384, 16'h0000});
        write_plane(REG_NEAR,   {16'sd4000,  16'sd16384, 16'h0000,  16'h0000});
        write_plane(REG_FAR,    {16'sd4000, -16'sd16384, 16'h0000,  16'h0000});
        @(negedge aclk);

        for (int k = 0; k < 6; k++) begin
            case (k / 2)
                0: begin snd_idle_pct = 6;  rcv_idle_pct = 47; end
                1: begin snd_idle_pct = 47; rcv_idle_pct = 6;  end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            if (k != 0) set_planes(plane_style_t'(k % 3));
            for (int n = 0; n < CHUNK_ITEMS; n++) pending_items.push_back(rand_item());
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (n_err == 0) begin
            $display("frustum_cull_test: match");
        end else begin
            $display("frustum_cull_test: mismatch");
        end
        $finish;
    end

endmodule
